// ===== design/slt_pkg.sv =====
// Package for the scene language tokenizer: token kinds, scan modes, token record
// and the character class and keyword helper functions. No dependencies.
package slt_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int LINE_W            = 24;
  localparam int POS_W             = 32;
  localparam int OUT_LEN_W         = 16;
  localparam int KIND_W            = 5;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_AW          = 2;

  localparam logic [KIND_W-1:0] K_EOF    = 5'd0;
  localparam logic [KIND_W-1:0] K_UNK    = 5'd1;
  localparam logic [KIND_W-1:0] K_SYM    = 5'd2;
  localparam logic [KIND_W-1:0] K_LE     = 5'd3;
  localparam logic [KIND_W-1:0] K_GE     = 5'd4;
  localparam logic [KIND_W-1:0] K_AND    = 5'd5;
  localparam logic [KIND_W-1:0] K_OR     = 5'd6;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd7;
  localparam logic [KIND_W-1:0] K_NE     = 5'd8;
  localparam logic [KIND_W-1:0] K_INT    = 5'd9;
  localparam logic [KIND_W-1:0] K_FLOAT  = 5'd10;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd11;
  localparam logic [KIND_W-1:0] K_STRING = 5'd12;
  localparam logic [KIND_W-1:0] K_FUNC   = 5'd13;
  localparam logic [KIND_W-1:0] K_IF     = 5'd14;
  localparam logic [KIND_W-1:0] K_ELSE   = 5'd15;
  localparam logic [KIND_W-1:0] K_VAR    = 5'd16;
  localparam logic [KIND_W-1:0] K_WHILE  = 5'd17;
  localparam logic [KIND_W-1:0] K_RGB    = 5'd18;
  localparam logic [KIND_W-1:0] K_VEC2   = 5'd19;
  localparam logic [KIND_W-1:0] K_VEC3   = 5'd20;
  localparam logic [KIND_W-1:0] K_VEC4   = 5'd21;
  localparam logic [KIND_W-1:0] K_INCL   = 5'd22;
  localparam logic [KIND_W-1:0] K_DECL   = 5'd23;
  localparam logic [KIND_W-1:0] K_WORLD  = 5'd24;
  localparam logic [KIND_W-1:0] K_BOOL   = 5'd25;
  localparam logic [KIND_W-1:0] K_SETT   = 5'd26;
  localparam logic [KIND_W-1:0] K_UNTERM = 5'd27;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_PEND, MODE_NUM, MODE_WORD, MODE_STR, MODE_ESC, MODE_CMT
  } scan_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [7:0]           symbol_char;
    logic [POS_W-1:0]     start_offset;
    logic [OUT_LEN_W-1:0] text_length;
    logic [LINE_W-1:0]    line_number;
    logic                 has_escape;
    logic                 last_of_run;
  } token_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

  function automatic logic is_wordch(input logic [7:0] b);
    return (b != 8'h00) && !is_space(b) && !is_punct(b);
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    case (b)
      ":", ".", "#", "^", "[", "]", "-", "(", ")", "{", "}", ";", ",", "+", "*":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_pend(input logic [7:0] b);
    return b == "<" || b == ">" || b == "!" || b == "&" || b == "|" || b == "=" || b == "/";
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] c);
    case (c)
      "<": return K_LE;
      ">": return K_GE;
      "&": return K_AND;
      "|": return K_OR;
      "=": return K_EQ;
      default: return K_NE;
    endcase
  endfunction

  // Keyword lookup on the first eight lowered bytes (zero padded) plus the length.
  function automatic logic [KIND_W-1:0] keyword_kind(input logic [63:0] w,
                                                     input logic [3:0] n);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    case (n)
      4'd2: if (w[15:0] == 16'h6669) k = K_IF;
      4'd3: begin
        if (w[23:0] == 24'h726176) k = K_VAR;
        if (w[23:0] == 24'h626772) k = K_RGB;
      end
      4'd4: begin
        if (w[31:0] == 32'h65736c65) k = K_ELSE;
        if (w[31:0] == 32'h65757274) k = K_BOOL;
      end
      4'd5: begin
        if (w[39:0] == 40'h656c696877) k = K_WHILE;
        if (w[39:0] == 40'h646c726f77) k = K_WORLD;
        if (w[39:0] == 40'h65736c6166) k = K_BOOL;
      end
      4'd6: if (w[47:0] == 48'h726f74636576) k = K_VEC3;
      4'd7: begin
        if (w[55:0] == 56'h32726f74636576) k = K_VEC2;
        if (w[55:0] == 56'h33726f74636576) k = K_VEC3;
        if (w[55:0] == 56'h34726f74636576) k = K_VEC4;
        if (w[55:0] == 56'h6564756c636e69) k = K_INCL;
        if (w[55:0] == 56'h6572616c636564) k = K_DECL;
      end
      4'd8: begin
        if (w == 64'h6e6f6974636e7566) k = K_FUNC;
        if (w == 64'h73676e6974746573) k = K_SETT;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== design/scene_language_tokenizer.sv =====
// Scene language tokenizer, one byte per transfer in and one token descriptor
// per transfer out; the scanner and a four-entry token queue. Depends on slt_pkg,
// slt_scan and slt_queue.
//
// Text bytes enter one per transfer, with s_tlast on the final byte of a text;
// token descriptors leave one per transfer, the token kind in m_tuser and m_tlast
// on the last token that a byte caused. A byte can be taken every cycle while
// s_tready is high: the scanner handles it in that cycle and its tokens enter
// the queue. A byte yields zero to three tokens, and s_tready is low while the
// queue could not take three more, that is while it holds three or more tokens,
// or two with no output transfer in the same cycle. A token that needs one
// character of lookahead comes out with the byte that ends it; end_of_text
// flushes any held token, adds the end of text token and returns the scanner to
// its reset state.
module scene_language_tokenizer #(
  parameter int KEYWORD_CHARS = slt_pkg::KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = slt_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // symbol_char, start_offset, text_length,
                                 // line_number, has_escape, zero fill
  output logic [4:0]  m_tuser,   // kind
  output logic        m_tlast    // last_of_run
);
  import slt_pkg::*;

  logic [1:0] cnt;
  token_t t0, t1, t2, o;
  logic room, acc;

  assign s_tready = room;
  assign acc = s_tvalid && s_tready;

  slt_scan #(.KEYWORD_CHARS(KEYWORD_CHARS), .LENGTH_BITS(LENGTH_BITS)) u_scan (
    .clk, .rst, .in_valid(acc), .in_byte(s_tdata), .in_eot(s_tlast),
    .tok_count(cnt), .tok0(t0), .tok1(t1), .tok2(t2)
  );

  slt_queue u_queue (
    .clk, .rst, .push_count(cnt), .push0(t0), .push1(t1), .push2(t2),
    .room, .out_valid(m_tvalid), .out_ready(m_tready), .out_tok(o)
  );

  assign m_tdata = {7'b0000000, o.has_escape, o.line_number, o.text_length,
                    o.start_offset, o.symbol_char};
  assign m_tuser = o.kind;
  assign m_tlast = o.last_of_run;
endmodule

// ===== design/slt_scan.sv =====
// Front part of the tokenizer: scans one byte per transfer and produces up to
// three token records. Depends on slt_pkg.
module slt_scan #(
  parameter int KEYWORD_CHARS = slt_pkg::KEYWORD_CHARS_DEF,
  parameter int LENGTH_BITS   = slt_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_eot,
  output logic [1:0]      tok_count,
  output slt_pkg::token_t tok0,
  output slt_pkg::token_t tok1,
  output slt_pkg::token_t tok2
);
  import slt_pkg::*;

  localparam int KW_AW = $clog2(KEYWORD_CHARS);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

  scan_mode_t mode, mode_next;
  logic [7:0] held_char, held_char_next;
  logic [7:0] kw_window [KEYWORD_CHARS];
  logic [LENGTH_BITS-1:0] token_length, token_length_next;
  logic [POS_W-1:0] token_start, token_start_next, stream_position;
  logic [LINE_W-1:0] line_count, line_count_next, token_line, token_line_next;
  logic dot_seen, dot_seen_next, escape_seen, escape_seen_next;
  logic grow_en;
  logic [7:0] grow_byte;

  token_t t [3];
  logic [1:0] n;
  logic [63:0] kw_flat;
  logic [KIND_W-1:0] word_kind;
  logic [OUT_LEN_W-1:0] len_out;
  logic used;

  always_comb begin
    kw_flat = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < KEYWORD_CHARS) kw_flat[i*8 +: 8] = kw_window[i];
    end
  end

  always_comb begin
    if (token_length > LENGTH_BITS'(KEYWORD_CHARS) || token_length > LENGTH_BITS'(8))
      word_kind = K_IDENT;
    else
      word_kind = keyword_kind(kw_flat, token_length[3:0]);
    if (LENGTH_BITS > OUT_LEN_W && token_length > LENGTH_BITS'({OUT_LEN_W{1'b1}}))
      len_out = {OUT_LEN_W{1'b1}};
    else
      len_out = OUT_LEN_W'(token_length);
  end

  function automatic token_t mk(input logic [KIND_W-1:0] k, input logic [7:0] s,
                                input logic [POS_W-1:0] st, input logic [OUT_LEN_W-1:0] l,
                                input logic [LINE_W-1:0] ln, input logic e);
    token_t r;
    r.kind = k; r.symbol_char = s; r.start_offset = st; r.text_length = l;
    r.line_number = ln; r.has_escape = e; r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LENGTH_BITS-1:0] l);
    if (LENGTH_BITS > OUT_LEN_W && l > LENGTH_BITS'({OUT_LEN_W{1'b1}}))
      return {OUT_LEN_W{1'b1}};
    return OUT_LEN_W'(l);
  endfunction

  always_comb begin
    logic [LINE_W-1:0] lc;
    logic [LENGTH_BITS-1:0] tl;
    scan_mode_t m;
    logic flush;
    logic [63:0] kw_a;
    logic [2:0] wi;
    mode_next = mode; held_char_next = held_char; token_length_next = token_length;
    token_start_next = token_start; token_line_next = token_line;
    dot_seen_next = dot_seen; escape_seen_next = escape_seen;
    grow_en = 1'b0; grow_byte = in_byte;
    n = 2'd0; used = 1'b0; flush = 1'b0;
    t[0] = '0; t[1] = '0; t[2] = '0;
    lc = line_count;
    tl = token_length;
    m = mode;
    unique case (mode)
      MODE_PEND: begin
        if (in_byte == (((held_char == "<") || (held_char == ">") || (held_char == "!"))
                        ? 8'h3D : held_char)) begin
          used = 1'b1;
          if (held_char == "/") m = MODE_CMT;
          else begin
            t[0] = mk(pair_kind(held_char), 8'd0, token_start, 16'd2, token_line, 1'b0);
            n = 2'd1; m = MODE_IDLE;
          end
        end else flush = 1'b1;
      end
      MODE_NUM: begin
        if (is_wordch(in_byte) || (in_byte == "." && !dot_seen)) begin
          if (in_byte == ".") dot_seen_next = 1'b1;
          grow_en = 1'b1; used = 1'b1;
          if (tl != LEN_MAX) tl = tl + 1'b1;
        end else flush = 1'b1;
      end
      MODE_WORD: begin
        if (is_wordch(in_byte) || in_byte == "_") begin
          grow_en = 1'b1; used = 1'b1;
          if (tl != LEN_MAX) tl = tl + 1'b1;
        end else flush = 1'b1;
      end
      MODE_STR: begin
        used = 1'b1;
        if (in_byte == 8'h27) begin
          t[0] = mk(K_STRING, 8'd0, token_start, len_out, token_line, escape_seen);
          n = 2'd1; m = MODE_IDLE;
        end else begin
          if (in_byte == 8'h5C) begin escape_seen_next = 1'b1; m = MODE_ESC; end
          if (in_byte == 8'h0A && lc != LINE_MAX) lc = lc + 1'b1;
          if (tl != LEN_MAX) tl = tl + 1'b1;
        end
      end
      MODE_ESC: begin
        used = 1'b1;
        if (in_byte == 8'h0A && lc != LINE_MAX) lc = lc + 1'b1;
        if (tl != LEN_MAX) tl = tl + 1'b1;
        m = MODE_STR;
      end
      MODE_CMT: begin
        used = 1'b1;
        if (in_byte == 8'h0A) begin
          if (lc != LINE_MAX) lc = lc + 1'b1;
          m = MODE_IDLE;
        end
      end
      default: m = MODE_IDLE;
    endcase
    if (flush) begin
      unique case (mode)
        MODE_PEND: t[0] = mk(K_SYM, held_char, token_start, 16'd1, token_line, 1'b0);
        MODE_NUM:  t[0] = mk(dot_seen ? K_FLOAT : K_INT, 8'd0, token_start, len_out,
                             token_line, 1'b0);
        default:   t[0] = mk(word_kind, 8'd0, token_start, len_out, token_line, 1'b0);
      endcase
      n = 2'd1; m = MODE_IDLE;
    end
    if (!used) begin
      if (is_space(in_byte)) begin
        if (in_byte == 8'h0A && lc != LINE_MAX) lc = lc + 1'b1;
      end else begin
        token_start_next = stream_position;
        token_line_next = lc;
        if (is_pend(in_byte)) begin
          m = MODE_PEND; held_char_next = in_byte;
        end else if (in_byte >= "0" && in_byte <= "9") begin
          m = MODE_NUM; tl = LENGTH_BITS'(1); dot_seen_next = 1'b0; grow_en = 1'b1;
        end else if ((to_lower(in_byte) >= "a" && to_lower(in_byte) <= "z")
                     || in_byte == "_") begin
          m = MODE_WORD; tl = LENGTH_BITS'(1); grow_en = 1'b1;
        end else if (in_byte == 8'h27) begin
          m = MODE_STR; token_start_next = stream_position + 1'b1;
          tl = '0; escape_seen_next = 1'b0;
        end else begin
          t[n] = mk(is_symbol(in_byte) ? K_SYM : K_UNK, in_byte, stream_position, 16'd1,
                    lc, 1'b0);
          n = n + 1'b1;
        end
      end
    end
    token_length_next = tl;
    line_count_next = lc;
    mode_next = m;
    // Lowered window with the byte of this transfer written in, for a word ending now.
    kw_a = kw_flat;
    wi = tl[2:0] - 3'd1;
    if (grow_en && tl != '0 && tl <= LENGTH_BITS'(8)
        && tl <= LENGTH_BITS'(KEYWORD_CHARS))
      kw_a[{wi, 3'b000} +: 8] = to_lower(grow_byte);
    if (in_eot) begin
      // Final byte: flush whatever is held, then the end of text token.
      unique case (m)
        MODE_PEND: begin
          t[n] = mk(K_SYM, held_char_next, token_start_next, 16'd1, token_line_next, 1'b0);
          n = n + 1'b1;
        end
        MODE_NUM, MODE_WORD: begin
          // These only stay open when this byte grew or began them.
          t[n] = mk((m == MODE_WORD)
                    ? ((tl > LENGTH_BITS'(KEYWORD_CHARS) || tl > LENGTH_BITS'(8))
                       ? K_IDENT : keyword_kind(kw_a, tl[3:0]))
                    : (dot_seen_next ? K_FLOAT : K_INT), 8'd0, token_start_next,
                    sat_len(tl), token_line_next, 1'b0);
          n = n + 1'b1;
        end
        MODE_STR, MODE_ESC: begin
          t[n] = mk(K_UNTERM, 8'd0, token_start_next, sat_len(tl), token_line_next,
                    escape_seen_next);
          n = n + 1'b1;
        end
        default: ;
      endcase
      t[n] = mk(K_EOF, 8'd0, stream_position + 1'b1, 16'd0, lc, 1'b0);
      n = n + 1'b1;
    end
    if (n != 2'd0) t[n - 1'b1].last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE; held_char <= '0; token_length <= '0; token_start <= '0;
      stream_position <= '0; line_count <= LINE_W'(1); token_line <= LINE_W'(1);
      dot_seen <= 1'b0; escape_seen <= 1'b0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kw_window[i] <= '0;
    end else if (in_valid) begin
      if (in_eot) begin
        mode <= MODE_IDLE; held_char <= '0; token_length <= '0; token_start <= '0;
        stream_position <= '0; line_count <= LINE_W'(1); token_line <= LINE_W'(1);
        dot_seen <= 1'b0; escape_seen <= 1'b0;
        for (int i = 0; i < KEYWORD_CHARS; i++) kw_window[i] <= '0;
      end else begin
        mode <= mode_next; held_char <= held_char_next;
        token_length <= token_length_next; token_start <= token_start_next;
        stream_position <= stream_position + 1'b1;
        line_count <= line_count_next; token_line <= token_line_next;
        dot_seen <= dot_seen_next; escape_seen <= escape_seen_next;
        if (grow_en && token_length_next != '0
            && token_length_next <= LENGTH_BITS'(KEYWORD_CHARS))
          kw_window[KW_AW'(token_length_next - 1'b1)] <= to_lower(grow_byte);
      end
    end
  end

  assign tok_count = in_valid ? n : 2'd0;
  assign tok0 = t[0];
  assign tok1 = t[1];
  assign tok2 = t[2];

  property p_eot_ends_run;
    @(posedge clk) disable iff (rst) (in_valid && in_eot) |-> (tok_count != 2'd0);
  endproperty
  a_eot_ends_run: assert property (p_eot_ends_run) else $error("eot gave no token");

  a_eot_resets: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_eot) |=> (mode == MODE_IDLE && stream_position == '0))
    else $error("state not reset after end of text");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst) line_count != '0)
    else $error("line count reached zero");
endmodule

// ===== design/slt_queue.sv =====
// Token queue and output serializer: takes up to three token records per
// transfer and hands them out one per transfer. Depends on slt_pkg.
module slt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  slt_pkg::token_t push0,
  input  slt_pkg::token_t push1,
  input  slt_pkg::token_t push2,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output slt_pkg::token_t out_tok
);
  import slt_pkg::*;

  localparam int CNT_W = QUEUE_AW + 2;

  token_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic pop;

  assign pop = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_tok = mem[rd_ptr];
  // Room for a full burst of three, counting a pop in this cycle.
  assign room = (count + CNT_W'(3)) <= CNT_W'(QUEUE_DEPTH) + CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_count >= 2'd1) mem[wr_ptr] <= push0;
    if (push_count >= 2'd2) mem[wr_ptr + QUEUE_AW'(1)] <= push1;
    if (push_count == 2'd3) mem[wr_ptr + QUEUE_AW'(2)] <= push2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push_count);
      rd_ptr <= rd_ptr + QUEUE_AW'(pop);
      count <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("token queue overflow");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> $past(room) || room)
    else $error("push without room");
  a_pop_counts: assert property (@(posedge clk) disable iff (rst)
    (pop && push_count == 2'd0) |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not lower count");
endmodule
